// File: hw/rtl/tsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample qualifier package
// Shared widths, codes, reset values and transaction types.
// ----------------------------------------------------------------------------
package tsq_pkg;

	localparam int RAW_RES_W   = 13;
	localparam int INTERVAL_W  = 16;
	localparam int TIME_W      = 32;
	localparam int COORD_W     = 16;
	localparam int REPORT_X_W  = 10;
	localparam int REPORT_Y_W  = 9;
	localparam int ACTION_W    = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int PANEL_WIDTH_DEF  = 800;
	localparam int PANEL_HEIGHT_DEF = 480;

	localparam logic [RAW_RES_W-1:0]  RAW_WIDTH_RST       = RAW_RES_W'(800);
	localparam logic [RAW_RES_W-1:0]  RAW_HEIGHT_RST      = RAW_RES_W'(480);
	localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST    = INTERVAL_W'(8);
	localparam logic [INTERVAL_W-1:0] ACTIVE_INTERVAL_RST = INTERVAL_W'(16);
	localparam logic [INTERVAL_W-1:0] IDLE_INTERVAL_RST   = INTERVAL_W'(250);
	localparam logic [INTERVAL_W-1:0] SCR_OFF_INTERVAL_RST = INTERVAL_W'(50);

	typedef enum logic [ACTION_W-1:0] {
		ACT_POLL       = 3'd0,
		ACT_IRQ_EDGE   = 3'd1,
		ACT_SUPPRESS   = 3'd2,
		ACT_SCREEN_OFF = 3'd3,
		ACT_TAKE_TAP   = 3'd4,
		ACT_TAKE_WAKE  = 3'd5
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RAW_WIDTH        = 3'd0,
		CFG_RAW_HEIGHT       = 3'd1,
		CFG_MIN_INTERVAL     = 3'd2,
		CFG_ACTIVE_INTERVAL  = 3'd3,
		CFG_IDLE_INTERVAL    = 3'd4,
		CFG_SCR_OFF_INTERVAL = 3'd5,
		CFG_IRQ_LINE_PRESENT = 3'd6
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACT,
		ST_X,
		ST_XW,
		ST_Y,
		ST_YW,
		ST_DONE
	} tsq_state_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [TIME_W-1:0]   now_ms;
		logic                backlight_on;
		logic                read_ok;
		logic                touch_pressed;
		logic [COORD_W-1:0]  raw_x;
		logic [COORD_W-1:0]  raw_y;
		logic                int_pin_low;
	} in_item_t;

	typedef struct packed {
		logic                  sampled;
		logic                  report_pressed;
		logic                  point_written;
		logic [REPORT_X_W-1:0] report_x;
		logic [REPORT_Y_W-1:0] report_y;
		logic                  tap_event;
		logic                  wake_event;
	} out_item_t;

endpackage

// File: hw/rtl/tsq_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample qualifier stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tsq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tsq_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample qualifier axis scaler
// Clamp, multiply by panel span, then restoring division one bit per cycle.
// ----------------------------------------------------------------------------
module tsq_scaler
	import tsq_pkg::*;
#(
	parameter int QUOT_W = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [COORD_W-1:0]   raw,
	input  logic [RAW_RES_W-1:0] res,
	input  logic [QUOT_W-1:0]    top,
	output logic                 done,
	output logic [QUOT_W-1:0]    quot
);

	localparam int CNT_W  = $clog2(QUOT_W + 1);
	localparam int PROD_W = RAW_RES_W + QUOT_W;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 zero_q;
	logic [RAW_RES_W-1:0] span_q;
	logic [RAW_RES_W-1:0] rem_q;
	logic [QUOT_W-1:0]    lo_q;

	logic [RAW_RES_W-1:0] span_in;
	logic [RAW_RES_W-1:0] raw_c;
	logic [PROD_W-1:0]    prod;
	logic [RAW_RES_W:0]   trial;
	logic [RAW_RES_W:0]   diff;
	logic                 ge;

	assign span_in = res - RAW_RES_W'(1);
	assign raw_c   = (raw > COORD_W'(span_in)) ? span_in : raw[RAW_RES_W-1:0];
	assign prod    = PROD_W'(raw_c) * PROD_W'(top);
	assign trial   = {rem_q, lo_q[QUOT_W-1]};
	assign diff    = trial - {1'b0, span_q};
	assign ge      = (trial >= {1'b0, span_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			span_q        <= span_in;
			zero_q        <= (res <= RAW_RES_W'(1));
			{rem_q, lo_q} <= prod;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RAW_RES_W-1:0] : trial[RAW_RES_W-1:0];
			lo_q  <= QUOT_W'({lo_q, ge});
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : lo_q;

endmodule

// File: hw/rtl/touch_sample_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample qualifier
// Poll gating, stored touch point, tap/wake events and scaled report.
// ----------------------------------------------------------------------------
// channel  dir  payload     transaction
// poll     in   in_item_t   poll.valid && poll.ready
// report   out  out_item_t  report.valid && report.ready
// cfg      in   index/data  cfg_we
//
// A transaction steps through ACT, X, XW, Y and YW to DONE. QUOT_W = clog2 of
// the larger panel dimension; the shared bit-serial divider runs once per axis.
// poll.ready is high only in IDLE. A finished result sits in the output
// register, so the next poll is taken while it waits; a new result waits in
// DONE until the register is free. Reset is asynchronous.
// ----------------------------------------------------------------------------
module touch_sample_qualifier
	import tsq_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	tsq_stream_if.sink             poll,
	tsq_stream_if.source           report
);

	localparam int PANEL_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
	localparam int QUOT_W    = $clog2(PANEL_MAX);
	localparam logic [QUOT_W-1:0] TOP_X = QUOT_W'(PANEL_WIDTH - 1);
	localparam logic [QUOT_W-1:0] TOP_Y = QUOT_W'(PANEL_HEIGHT - 1);

	// configuration
	logic [RAW_RES_W-1:0]  raw_width_q;
	logic [RAW_RES_W-1:0]  raw_height_q;
	logic [INTERVAL_W-1:0] min_interval_q;
	logic [INTERVAL_W-1:0] active_interval_q;
	logic [INTERVAL_W-1:0] idle_interval_q;
	logic [INTERVAL_W-1:0] scr_off_interval_q;
	logic                  irq_line_q;

	// block state
	logic [COORD_W-1:0] stored_x_q;
	logic [COORD_W-1:0] stored_y_q;
	logic               stored_pressed_q;
	logic               stored_valid_q;
	logic               suppress_q;
	logic               tap_latch_q;
	logic [TIME_W-1:0]  last_time_q;
	logic               irq_pending_q;
	logic               wake_pending_q;

	tsq_state_t state_q, state_d;
	in_item_t   item_q;
	logic       sampled_q;
	logic       tap_ev_q;
	logic       wake_ev_q;
	logic [QUOT_W-1:0] x_q;
	logic [QUOT_W-1:0] y_q;
	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       scl_start;
	logic       sel_y;
	logic       load_out;
	logic       scl_done;
	logic [QUOT_W-1:0] scl_quot;

	logic [TIME_W-1:0]     elapsed;
	logic [INTERVAL_W-1:0] fb_interval;
	logic                  below_min;
	logic                  below_fb;
	logic                  take;
	logic                  hide;
	logic                  out_free;

	assign poll.ready   = (state_q == ST_IDLE);
	assign report.valid = out_valid_q;
	assign report.data  = out_data_q;
	assign out_free     = !out_valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_width_q        <= RAW_WIDTH_RST;
			raw_height_q       <= RAW_HEIGHT_RST;
			min_interval_q     <= MIN_INTERVAL_RST;
			active_interval_q  <= ACTIVE_INTERVAL_RST;
			idle_interval_q    <= IDLE_INTERVAL_RST;
			scr_off_interval_q <= SCR_OFF_INTERVAL_RST;
			irq_line_q         <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_RAW_WIDTH:        raw_width_q        <= cfg_wdata[RAW_RES_W-1:0];
				CFG_RAW_HEIGHT:       raw_height_q       <= cfg_wdata[RAW_RES_W-1:0];
				CFG_MIN_INTERVAL:     min_interval_q     <= cfg_wdata;
				CFG_ACTIVE_INTERVAL:  active_interval_q  <= cfg_wdata;
				CFG_IDLE_INTERVAL:    idle_interval_q    <= cfg_wdata;
				CFG_SCR_OFF_INTERVAL: scr_off_interval_q <= cfg_wdata;
				CFG_IRQ_LINE_PRESENT: irq_line_q         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// poll gating
	assign elapsed     = item_q.now_ms - last_time_q;
	assign fb_interval = !item_q.backlight_on ? scr_off_interval_q :
	                     (stored_pressed_q ? active_interval_q : idle_interval_q);
	assign below_min   = stored_valid_q && (elapsed < TIME_W'(min_interval_q));
	assign below_fb    = irq_line_q && !irq_pending_q && (elapsed < TIME_W'(fb_interval));
	assign take        = !below_min && !below_fb;

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_q <= poll.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_x_q       <= '0;
			stored_y_q       <= '0;
			stored_pressed_q <= 1'b0;
			stored_valid_q   <= 1'b0;
			suppress_q       <= 1'b0;
			tap_latch_q      <= 1'b0;
			last_time_q      <= '0;
			irq_pending_q    <= 1'b1;
			wake_pending_q   <= 1'b0;
			sampled_q        <= 1'b0;
			tap_ev_q         <= 1'b0;
			wake_ev_q        <= 1'b0;
		end else if (state_q == ST_ACT) begin
			sampled_q <= 1'b0;
			tap_ev_q  <= 1'b0;
			wake_ev_q <= 1'b0;
			unique case (action_t'(item_q.action))
				ACT_POLL: begin
					if (take) begin
						irq_pending_q <= 1'b0;
						last_time_q   <= item_q.now_ms;
						if (item_q.read_ok) begin
							sampled_q <= 1'b1;
							if (suppress_q && !item_q.touch_pressed) begin
								suppress_q <= 1'b0;
							end
							if (item_q.touch_pressed && !stored_pressed_q && !suppress_q) begin
								tap_latch_q <= 1'b1;
							end
							if (item_q.touch_pressed) begin
								stored_x_q <= item_q.raw_x;
								stored_y_q <= item_q.raw_y;
							end
							stored_pressed_q <= item_q.touch_pressed;
							stored_valid_q   <= 1'b1;
						end
					end
				end
				ACT_IRQ_EDGE: begin
					irq_pending_q  <= 1'b1;
					wake_pending_q <= 1'b1;
				end
				ACT_SUPPRESS: begin
					suppress_q  <= 1'b1;
					tap_latch_q <= 1'b0;
				end
				ACT_SCREEN_OFF: begin
					wake_pending_q <= 1'b0;
					irq_pending_q  <= irq_line_q && item_q.int_pin_low;
					tap_latch_q    <= 1'b0;
				end
				ACT_TAKE_TAP: begin
					tap_ev_q    <= tap_latch_q;
					tap_latch_q <= 1'b0;
				end
				ACT_TAKE_WAKE: begin
					wake_ev_q      <= wake_pending_q;
					wake_pending_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// shared scaler, x then y
	tsq_scaler #(
		.QUOT_W (QUOT_W)
	) u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.raw    (sel_y ? stored_y_q : stored_x_q),
		.res    (sel_y ? raw_height_q : raw_width_q),
		.top    (sel_y ? TOP_Y : TOP_X),
		.done   (scl_done),
		.quot   (scl_quot)
	);

	always_ff @(posedge clk) begin
		if (scl_done && (state_q == ST_XW)) begin
			x_q <= scl_quot;
		end
		if (scl_done && (state_q == ST_YW)) begin
			y_q <= scl_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (poll.valid) state_d = ST_ACT;
			ST_ACT:  state_d = ST_X;
			ST_X:    state_d = ST_XW;
			ST_XW:   if (scl_done) state_d = ST_Y;
			ST_Y:    state_d = ST_YW;
			ST_YW:   if (scl_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		scl_start = 1'b0;
		sel_y     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_X:    scl_start = 1'b1;
			ST_Y: begin
				scl_start = 1'b1;
				sel_y     = 1'b1;
			end
			ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	// output register
	assign hide = suppress_q || (stored_pressed_q && !item_q.backlight_on);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.sampled        <= sampled_q;
			out_data_q.report_pressed <= stored_valid_q && !hide && stored_pressed_q;
			out_data_q.point_written  <= stored_valid_q && !hide;
			out_data_q.report_x       <= stored_valid_q ? REPORT_X_W'(x_q) : '0;
			out_data_q.report_y       <= stored_valid_q ? REPORT_Y_W'(y_q) : '0;
			out_data_q.tap_event      <= tap_ev_q;
			out_data_q.wake_event     <= wake_ev_q;
		end
	end

	// checks
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		scl_done |-> (state_q == ST_XW || state_q == ST_YW))
		else $error("scaler done outside a wait state");

	a_accept_to_act: assert property (@(posedge clk) disable iff (!arst_n)
		(poll.valid && poll.ready) |=> (state_q == ST_ACT))
		else $error("accepted poll did not start the action step");

	a_pressed_written: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.report_pressed) |-> out_data_q.point_written)
		else $error("pressed reported without point update");

	a_sampled_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.sampled) |-> stored_valid_q)
		else $error("sample reported with no valid stored point");

endmodule
